// ===== hdl/cet_pkg.sv =====
// Package for the countdown expiry table: shared constants, FSM state type,
// opcodes and the per-cell control struct.
// No dependencies.
`default_nettype none

package cet_pkg;

  // Default parameter values
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DefTimeBits = 16;

  // Fixed widths of the item fields
  localparam int unsigned FieldTimeW = 16;
  localparam int unsigned KindW      = 3;
  localparam int unsigned LeftW      = 5;

  // Input opcodes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } cet_op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_QUIET
  } cet_state_e;

  // Control handed to each cell of the chain
  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic load;   // take the write data (wins over shift)
  } cet_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/countdown_expiry_table_core.sv =====
// Countdown expiry table top level: controller, output register and the
// chain of entry cells. Depends on cet_pkg and cet_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: an add with kind
//   and start time, or a tick with the elapsed time. Output channel
//   (out_valid_o/out_ready_i) carries the results of that item.
//   An add's result is registered and shows in the cycle after it is taken.
//   A tick over N held entries walks the chain twice through its head cell:
//   one pass counts the expiring entries, a second pass drops them (one
//   result each, in table order) and writes the others back with the elapsed
//   time subtracted. A tick with no expiry ends in one empty result. A tick
//   on an empty table answers at once, its result registered like an add's.
//   Adds can be taken one item every cycle; a tick holds off new items until
//   both of its passes, and its empty result if any, are done.
//   A new item is taken only while the controller is idle and the output
//   register is free or its result leaves in the same cycle.
//   A stalled receiver holds the chain in the second pass until the pending
//   result is taken. Reset empties the table (cell contents are not cleared)
//   and drops any pending result.
`default_nettype none

module countdown_expiry_table_core #(
  parameter int unsigned Capacity = cet_pkg::DefCapacity,
  parameter int unsigned TimeBits = cet_pkg::DefTimeBits
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              opcode_i,
  input  wire logic [cet_pkg::KindW-1:0]         kind_i,
  input  wire logic [cet_pkg::FieldTimeW-1:0]    start_time_i,
  input  wire logic [cet_pkg::FieldTimeW-1:0]    elapsed_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   accepted_o,
  output logic                                   expired_valid_o,
  output logic      [cet_pkg::KindW-1:0]         expired_kind_o,
  output logic      [cet_pkg::LeftW-1:0]         entries_left_o,
  output logic                                   last_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (TimeBits > cet_pkg::FieldTimeW) ?
                                 TimeBits : cet_pkg::FieldTimeW;
  localparam int unsigned KW   = cet_pkg::KindW;

  cet_pkg::cet_state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;        // entries not yet walked
  logic [CntW-1:0] k_q, k_d;        // entries kept so far
  logic [CntW-1:0] gone_q, gone_d;  // expired entries counted in the scan
  logic [CntW-1:0] emit_q, emit_d;  // expired entries already emitted
  logic [cet_pkg::FieldTimeW-1:0] elapsed_q, elapsed_d;

  // Output register
  logic            out_valid_q;
  logic            acc_q, xv_q, last_q;
  logic [KW-1:0]   xk_q;
  logic [cet_pkg::LeftW-1:0] left_q;
  logic            out_load, out_acc, out_xv, out_last;
  logic [KW-1:0]   out_kind;
  logic [CntW-1:0] out_left;
  logic            slot_free;

  // Chain signals
  logic [KW-1:0]       cell_kind [Capacity];
  logic [TimeBits-1:0] cell_rem  [Capacity];
  logic                shift_en, wr_en;
  logic [CntW-1:0]     wr_pos;
  logic [KW-1:0]       wr_kind;
  logic [TimeBits-1:0] wr_rem;

  // Head cell and its expiry test
  logic [CmpW-1:0] head_ext, elapsed_ext, diff;
  logic            head_expired;
  logic [CmpW-1:0] start_ext, max_ext, start_sat;

  logic in_fire, last_step, full;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign full      = (count_q >= CntW'(Capacity));
  assign last_step = (n_q == CntW'(1));

  assign head_ext     = CmpW'(cell_rem[0]);
  assign elapsed_ext  = CmpW'(elapsed_q);
  assign head_expired = (head_ext <= elapsed_ext);
  assign diff         = head_ext - elapsed_ext;

  // Saturate the start time to the entry width
  assign start_ext = CmpW'(start_time_i);
  assign max_ext   = CmpW'({TimeBits{1'b1}});
  assign start_sat = (start_ext > max_ext) ? max_ext : start_ext;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cet_pkg::ST_IDLE: begin
        if (in_fire && (opcode_i == cet_pkg::OP_TICK) && (count_q != '0)) begin
          state_d = cet_pkg::ST_SCAN;
        end
      end
      cet_pkg::ST_SCAN: begin
        if (last_step) begin
          state_d = cet_pkg::ST_COMPACT;
        end
      end
      cet_pkg::ST_COMPACT: begin
        if (last_step && (!head_expired || slot_free)) begin
          state_d = (gone_q == '0) ? cet_pkg::ST_QUIET : cet_pkg::ST_IDLE;
        end
      end
      cet_pkg::ST_QUIET: begin
        if (slot_free) begin
          state_d = cet_pkg::ST_IDLE;
        end
      end
      default: state_d = cet_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs: chain control, counters and result loading
  always_comb begin
    in_ready_o = 1'b0;
    shift_en   = 1'b0;
    wr_en      = 1'b0;
    wr_pos     = count_q;
    wr_kind    = cell_kind[0];
    wr_rem     = cell_rem[0];
    out_load   = 1'b0;
    out_acc    = 1'b1;
    out_xv     = 1'b0;
    out_kind   = '0;
    out_left   = count_q;
    out_last   = 1'b1;
    count_d    = count_q;
    n_d        = n_q;
    k_d        = k_q;
    gone_d     = gone_q;
    emit_d     = emit_q;
    elapsed_d  = elapsed_q;
    case (state_q)
      cet_pkg::ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_fire) begin
          if (opcode_i == cet_pkg::OP_ADD) begin
            // Append at the tail if there is room
            out_load = 1'b1;
            out_acc  = !full;
            if (!full) begin
              wr_en    = 1'b1;
              wr_pos   = count_q;
              wr_kind  = kind_i;
              wr_rem   = start_sat[TimeBits-1:0];
              count_d  = count_q + CntW'(1);
              out_left = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            // Empty table: answer at once
            out_load = 1'b1;
          end else begin
            elapsed_d = elapsed_i;
            n_d       = count_q;
            gone_d    = '0;
          end
        end
      end
      cet_pkg::ST_SCAN: begin
        // Rotate head to the tail unchanged, count expiries
        shift_en = 1'b1;
        wr_en    = 1'b1;
        wr_pos   = count_q - CntW'(1);
        if (head_expired) begin
          gone_d = gone_q + CntW'(1);
        end
        if (last_step) begin
          n_d    = count_q;
          k_d    = '0;
          emit_d = '0;
        end else begin
          n_d = n_q - CntW'(1);
        end
      end
      cet_pkg::ST_COMPACT: begin
        // Drop and emit expired head, or write it back aged
        if (!head_expired || slot_free) begin
          shift_en = 1'b1;
          n_d      = n_q - CntW'(1);
          if (head_expired) begin
            out_load = 1'b1;
            out_xv   = 1'b1;
            out_kind = cell_kind[0];
            out_left = count_q - gone_q;
            out_last = ((emit_q + CntW'(1)) == gone_q);
            emit_d   = emit_q + CntW'(1);
          end else begin
            wr_en  = 1'b1;
            wr_pos = n_q + k_q - CntW'(1);
            wr_rem = diff[TimeBits-1:0];
            k_d    = k_q + CntW'(1);
          end
          if (last_step) begin
            count_d = head_expired ? k_q : (k_q + CntW'(1));
          end
        end
      end
      cet_pkg::ST_QUIET: begin
        // Tick without expiry: one empty result
        if (slot_free) begin
          out_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cet_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk counters, elapsed time and result payload
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    gone_q    <= gone_d;
    emit_q    <= emit_d;
    elapsed_q <= elapsed_d;
    if (out_load) begin
      acc_q  <= out_acc;
      xv_q   <= out_xv;
      xk_q   <= out_kind;
      left_q <= cet_pkg::LeftW'(out_left);
      last_q <= out_last;
    end
  end

  // Chain of entry cells, head at index zero
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    cet_pkg::cet_cell_ctrl_t ctrl;
    logic [KW-1:0]           nb_kind;
    logic [TimeBits-1:0]     nb_rem;

    assign ctrl.shift = shift_en;
    assign ctrl.load  = wr_en && (wr_pos == CntW'(i));

    if (i == Capacity - 1) begin : g_tail
      assign nb_kind = '0;
      assign nb_rem  = '0;
    end else begin : g_mid
      assign nb_kind = cell_kind[i+1];
      assign nb_rem  = cell_rem[i+1];
    end

    cet_cell #(
      .TimeBits(TimeBits)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .nb_kind_i(nb_kind),
      .nb_rem_i (nb_rem),
      .wr_kind_i(wr_kind),
      .wr_rem_i (wr_rem),
      .kind_o   (cell_kind[i]),
      .rem_o    (cell_rem[i])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign expired_valid_o = xv_q;
  assign expired_kind_o  = xk_q;
  assign entries_left_o  = left_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

// ===== hdl/cet_cell.sv =====
// One cell of the entry chain: holds a kind code and a remaining time.
// Depends on cet_pkg.
`default_nettype none

module cet_cell #(
  parameter int unsigned TimeBits = cet_pkg::DefTimeBits
) (
  input  wire logic                        clk_i,
  input  wire cet_pkg::cet_cell_ctrl_t     ctrl_i,
  input  wire logic [cet_pkg::KindW-1:0]   nb_kind_i,
  input  wire logic [TimeBits-1:0]         nb_rem_i,
  input  wire logic [cet_pkg::KindW-1:0]   wr_kind_i,
  input  wire logic [TimeBits-1:0]         wr_rem_i,
  output logic      [cet_pkg::KindW-1:0]   kind_o,
  output logic      [TimeBits-1:0]         rem_o
);

  logic [cet_pkg::KindW-1:0] kind_q, kind_d;
  logic [TimeBits-1:0]       rem_q, rem_d;

  // Load wins, then shift from the neighbor, else hold
  always_comb begin
    kind_d = kind_q;
    rem_d  = rem_q;
    if (ctrl_i.load) begin
      kind_d = wr_kind_i;
      rem_d  = wr_rem_i;
    end else if (ctrl_i.shift) begin
      kind_d = nb_kind_i;
      rem_d  = nb_rem_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rem_q  <= rem_d;
  end

  assign kind_o = kind_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== tb/countdown_expiry_table_core_tb.sv =====
// Testbench for countdown_expiry_table_core: directed table plus random adds and ticks,
// with every result checked in order against directed expected values or a local model of the entry table.
// Depends on cet_pkg and the countdown_expiry_table_core RTL.

module countdown_expiry_table_core_tb;

  localparam int unsigned TblCap       = cet_pkg::DefCapacity;
  localparam int unsigned RandomItems  = 285;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 40;

  // One result of the block, packed in port order
  typedef struct packed {
    logic                      accepted;
    logic                      exp_valid;
    logic [cet_pkg::KindW-1:0] exp_kind;
    logic [cet_pkg::LeftW-1:0] left;
    logic                      last;
  } expiry_result_t;

  // One directed stimulus row; res only holds when typed is set
  typedef struct {
    cet_pkg::cet_op_e               op;
    logic [cet_pkg::KindW-1:0]      kind;
    logic [cet_pkg::FieldTimeW-1:0] start_time;
    logic [cet_pkg::FieldTimeW-1:0] elapsed;
    bit                             typed;
    expiry_result_t                 res;
  } stim_row_t;

  // Receiver stall behavior
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           opcode_i;
  logic [cet_pkg::KindW-1:0]      kind_i;
  logic [cet_pkg::FieldTimeW-1:0] start_time_i;
  logic [cet_pkg::FieldTimeW-1:0] elapsed_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           accepted_o;
  logic                           expired_valid_o;
  logic [cet_pkg::KindW-1:0]      expired_kind_o;
  logic [cet_pkg::LeftW-1:0]      entries_left_o;
  logic                           last_o;

  // Model of the entry table
  logic [cet_pkg::KindW-1:0]      tbl_kind [TblCap];
  logic [cet_pkg::FieldTimeW-1:0] tbl_time [TblCap];
  int unsigned                    tbl_count;

  expiry_result_t pending_results[$];
  stim_row_t      directed_rows[$];
  expiry_result_t seen_result;
  expiry_result_t want_result;

  // Driver side info for the item on the input port
  bit             drv_typed;
  expiry_result_t drv_typed_res;
  int unsigned    burst_left;

  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned items_taken;
  int unsigned ticks_taken;
  int unsigned rejects_seen;
  int unsigned expiries_seen;
  int unsigned results_seen;

  countdown_expiry_table_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .kind_i          (kind_i),
    .start_time_i    (start_time_i),
    .elapsed_i       (elapsed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .expired_valid_o (expired_valid_o),
    .expired_kind_o  (expired_kind_o),
    .entries_left_o  (entries_left_o),
    .last_o          (last_o)
  );

  // Clock and reset
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("countdown_expiry_table_core_tb: errors");
      $finish;
    end
  end

  // Apply one item to the table model and queue the results it causes
  function automatic void predict_expiry(cet_pkg::cet_op_e op,
                                         logic [cet_pkg::KindW-1:0] kind,
                                         logic [cet_pkg::FieldTimeW-1:0] start_time,
                                         logic [cet_pkg::FieldTimeW-1:0] elapsed,
                                         bit keep);
    expiry_result_t            r;
    logic [cet_pkg::KindW-1:0] gone[$];
    int unsigned               kept;
    r    = '0;
    kept = 0;
    if (op == cet_pkg::OP_ADD) begin
      if (tbl_count < TblCap) begin
        tbl_kind[tbl_count] = kind;
        tbl_time[tbl_count] = start_time;
        tbl_count++;
        r.accepted = 1'b1;
      end else begin
        rejects_seen++;
      end
      r.left = cet_pkg::LeftW'(tbl_count);
      r.last = 1'b1;
      if (keep) pending_results.push_back(r);
    end else begin
      // Drop expired entries, compact the rest and age them
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (tbl_time[i] <= elapsed) begin
          gone.push_back(tbl_kind[i]);
        end else begin
          tbl_kind[kept] = tbl_kind[i];
          tbl_time[kept] = tbl_time[i] - elapsed;
          kept++;
        end
      end
      tbl_count     = kept;
      expiries_seen += gone.size();
      r.accepted = 1'b1;
      r.left     = cet_pkg::LeftW'(tbl_count);
      if (gone.size() == 0) begin
        r.last = 1'b1;
        if (keep) pending_results.push_back(r);
      end else begin
        for (int i = 0; i < gone.size(); i++) begin
          r.exp_valid = 1'b1;
          r.exp_kind  = gone[i];
          r.last      = (i == gone.size() - 1);
          if (keep) pending_results.push_back(r);
        end
      end
    end
  endfunction

  // Check results and record accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen_result = {accepted_o, expired_valid_o, expired_kind_o, entries_left_o, last_o};
        results_seen++;
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: acc=%0d vld=%0d kind=%0d left=%0d last=%0d",
                     seen_result.accepted, seen_result.exp_valid, seen_result.exp_kind,
                     seen_result.left, seen_result.last);
        end else begin
          want_result = pending_results.pop_front();
          if (seen_result !== want_result) begin
            err_count++;
            if (err_count <= 10)
              $display({"result mismatch at cycle %0d: expected acc=%0d vld=%0d kind=%0d ",
                        "left=%0d last=%0d, got acc=%0d vld=%0d kind=%0d left=%0d last=%0d"},
                       cycle_count, want_result.accepted, want_result.exp_valid,
                       want_result.exp_kind, want_result.left, want_result.last,
                       seen_result.accepted, seen_result.exp_valid, seen_result.exp_kind,
                       seen_result.left, seen_result.last);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        items_taken++;
        if (opcode_i == cet_pkg::OP_TICK) ticks_taken++;
        predict_expiry(cet_pkg::cet_op_e'(opcode_i), kind_i, start_time_i, elapsed_i,
                       !drv_typed);
        if (drv_typed) pending_results.push_back(drv_typed_res);
      end
    end
  end

  // Receiver: stall behavior is drawn anew at random from open, random and sparse modes
  initial begin
    rx_mode_e    rx_mode;
    int unsigned mode_left;
    out_ready_i = 1'b0;
    rx_mode     = RX_OPEN;
    mode_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_ready_i = 1'b1;
        RX_RANDOM: out_ready_i = 1'($urandom_range(0, 1));
        default:   out_ready_i = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Present one item, with a random gap between bursts, and hold it until taken
  task automatic send_item(cet_pkg::cet_op_e op, logic [cet_pkg::KindW-1:0] kind,
                           logic [cet_pkg::FieldTimeW-1:0] start_time,
                           logic [cet_pkg::FieldTimeW-1:0] elapsed,
                           bit typed, expiry_result_t res);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    opcode_i      = op;
    kind_i        = kind;
    start_time_i  = start_time;
    elapsed_i     = elapsed;
    drv_typed     = typed;
    drv_typed_res = res;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold off the sender until every expected result has come
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(cet_pkg::cet_op_e op, logic [cet_pkg::KindW-1:0] kind,
                         logic [cet_pkg::FieldTimeW-1:0] start_time,
                         logic [cet_pkg::FieldTimeW-1:0] elapsed, bit typed,
                         logic acc, logic vld, logic [cet_pkg::KindW-1:0] ek,
                         logic [cet_pkg::LeftW-1:0] left, logic last);
    stim_row_t row;
    row.op         = op;
    row.kind       = kind;
    row.start_time = start_time;
    row.elapsed    = elapsed;
    row.typed      = typed;
    row.res        = {acc, vld, ek, left, last};
    directed_rows.push_back(row);
  endtask

  // Stimulus
  initial begin
    int unsigned                    pick;
    cet_pkg::cet_op_e               op;
    logic [cet_pkg::KindW-1:0]      kind;
    logic [cet_pkg::FieldTimeW-1:0] start_time;
    logic [cet_pkg::FieldTimeW-1:0] elapsed;
    in_valid_i    = 1'b0;
    opcode_i      = cet_pkg::OP_ADD;
    kind_i        = '0;
    start_time_i  = '0;
    elapsed_i     = '0;
    drv_typed     = 1'b0;
    drv_typed_res = '0;
    burst_left    = 0;
    tbl_count     = 0;
    cycle_count   = 0;
    err_count     = 0;
    items_taken   = 0;
    ticks_taken   = 0;
    rejects_seen  = 0;
    expiries_seen = 0;
    results_seen  = 0;

    // Tick on the empty table, zero-time entry, time extremes, quiet tick
    add_row(cet_pkg::OP_TICK, 0, 0, 0, 1, 1, 0, 0, 0, 1);
    add_row(cet_pkg::OP_ADD, 7, 0, 0, 1, 1, 0, 0, 1, 1);
    add_row(cet_pkg::OP_TICK, 0, 0, 0, 1, 1, 1, 7, 0, 1);
    add_row(cet_pkg::OP_ADD, 0, 16'hFFFF, 0, 1, 1, 0, 0, 1, 1);
    add_row(cet_pkg::OP_ADD, 5, 100, 0, 1, 1, 0, 0, 2, 1);
    add_row(cet_pkg::OP_TICK, 0, 0, 50, 1, 1, 0, 0, 2, 1);
    add_row(cet_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    // Fill the table, one start-time bit per entry, then overflow it
    for (int i = 0; i < TblCap; i++)
      add_row(cet_pkg::OP_ADD, cet_pkg::KindW'(i), cet_pkg::FieldTimeW'(1) << i, 0, 0,
              0, 0, 0, 0, 0);
    add_row(cet_pkg::OP_ADD, 3, 16'h1234, 0, 1, 0, 0, 0, 16, 1);
    // Expire the low half with compaction, then everything left
    add_row(cet_pkg::OP_TICK, 0, 0, 16'h00FF, 0, 0, 0, 0, 0, 0);
    add_row(cet_pkg::OP_TICK, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0);

    @(posedge rst_ni);
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].kind, directed_rows[i].start_time,
                directed_rows[i].elapsed, directed_rows[i].typed, directed_rows[i].res);
    wait_drained();

    // Random adds and ticks; short times so ticks expire part of the table
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) wait_drained();
      op   = ($urandom_range(0, 99) < 58) ? cet_pkg::OP_ADD : cet_pkg::OP_TICK;
      kind = cet_pkg::KindW'($urandom_range(0, 7));
      pick = $urandom_range(0, 9);
      case (pick)
        0:       start_time = '0;
        1:       start_time = cet_pkg::FieldTimeW'($urandom);
        2:       start_time = '1;
        default: start_time = cet_pkg::FieldTimeW'($urandom_range(1, 600));
      endcase
      pick = $urandom_range(0, 19);
      case (pick)
        0:       elapsed = '0;
        1:       elapsed = '1;
        2, 3:    elapsed = cet_pkg::FieldTimeW'($urandom);
        default: elapsed = cet_pkg::FieldTimeW'($urandom_range(0, 250));
      endcase
      send_item(op, kind, start_time, elapsed, 1'b0, '0);
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    if (pending_results.size() != 0) begin
      err_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("ran %0d items (%0d ticks, %0d adds refused by a full table)",
             items_taken, ticks_taken, rejects_seen);
    $display("checked %0d results, %0d of them expired entries; %0d failures",
             results_seen, expiries_seen, err_count);
    if (err_count == 0) begin
      $display("countdown_expiry_table_core_tb: clean");
    end else begin
      $display("countdown_expiry_table_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cet_pkg.sv
hdl/cet_cell.sv
hdl/countdown_expiry_table_core.sv
tb/countdown_expiry_table_core_tb.sv
